[hdl/iratc_pkg.sv]
// iratc_pkg: shared types and constants of the calibration table converter
// no dependencies; used by every file of the block
`default_nettype none
package iratc_pkg;

  localparam int CNT_W  = 16;
  localparam int TEMP_W = 16;
  localparam int CORR_W = 24;
  localparam int QT_W   = 24;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 2;
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 6;
  localparam int PTS_W  = 7;
  localparam int CFG_W  = 16;
  localparam int CFGI_W = 2;
  localparam int SAT_W  = 96;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEMP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BELOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABOVE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_BEGIN  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_POINTS = 2'd2;

  localparam logic [CNT_W-1:0] RST_BEGIN  = 16'd1000;
  localparam logic [CNT_W-1:0] RST_TOP    = 16'd65535;
  localparam logic [PTS_W-1:0] RST_POINTS = 7'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP_RD, S_SEARCH, S_SEG_LO, S_SEG_HI, S_CHECK,
    S_MUL1, S_DIV1, S_FIX1, S_MUL2, S_DIV2, S_FIX2, S_OUT
  } state_t;

  typedef struct packed {
    logic        [CNT_W-1:0]  count;
    logic signed [TEMP_W-1:0] temp;
    logic signed [CORR_W-1:0] corr;
  } point_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7fff_ffff);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/iratc_req_if.sv]
// iratc_req_if: input item channel, valid/ready with the item fields
// depends on iratc_pkg
`default_nettype none
interface iratc_req_if;
  import iratc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [FUNC_W-1:0] func;
  logic        [IDX_W-1:0]  entry_index;
  logic        [CNT_W-1:0]  entry_count;
  logic signed [TEMP_W-1:0] entry_temp;
  logic signed [CORR_W-1:0] entry_correction;
  logic        [CNT_W-1:0]  sample_count;
  logic signed [QT_W-1:0]   query_temp;

  modport source (output valid, func, entry_index, entry_count, entry_temp,
                  entry_correction, sample_count, query_temp, input ready);
  modport sink (input valid, func, entry_index, entry_count, entry_temp,
                entry_correction, sample_count, query_temp, output ready);
endinterface
`default_nettype wire

[hdl/iratc_rsp_if.sv]
// iratc_rsp_if: result channel, valid/ready with the result fields
// depends on iratc_pkg
`default_nettype none
interface iratc_rsp_if;
  import iratc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] temperature;
  logic        [CNT_W-1:0] count_value;
  logic       [STAT_W-1:0] status;

  modport source (output valid, temperature, count_value, status, input ready);
  modport sink (input valid, temperature, count_value, status, output ready);
endinterface
`default_nettype wire

[hdl/ir_ad_temperature_table_convert.sv]
// ir_ad_temperature_table_convert: count/temperature conversion over a calibration table
// depends on iratc_pkg, iratc_req_if, iratc_rsp_if, iratc_table, iratc_div
//
// Usage: items arrive on req (valid/ready). A load item (func 0) writes one
// calibration point in the transfer cycle and produces no result; func 3 is
// dropped. Count-to-temperature (func 1) and temperature-to-count (func 2)
// items each produce one result on rsp (valid/ready).
// A conversion walks the table one point at a time (registered memory read),
// reads its segment ends, then runs two multiply/divide passes through the
// shared serial divider, each forming a quotient of 58 + FRAC_BITS bits.
// A sample outside begin..top skips the walk; a query outside the table or a
// zero-width segment ends without the divider passes.
// req.ready is high only while the sequencer is idle; one item is worked on
// at a time.
// The result sits in an output register: a new item can be accepted while
// rsp is stalled, and only its own result step waits for rsp.ready.
// Reset (rst, synchronous) returns the sequencer to idle, drops any pending
// result and restores the configuration registers. Table contents are not
// cleared and must be loaded before use.
`default_nettype none
module ir_ad_temperature_table_convert #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  iratc_req_if.sink                    req,
  iratc_rsp_if.source                  rsp,
  input  wire                          cfg_we,
  input  wire [iratc_pkg::CFGI_W-1:0]  cfg_index,
  input  wire [iratc_pkg::CFG_W-1:0]   cfg_data
);
  import iratc_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int NPW   = $clog2(TABLE_DEPTH + 1);
  localparam int TO_W  = TEMP_W + FRAC_BITS;
  localparam int A_W   = 33;
  localparam int B_W   = 25;
  localparam int P_W   = A_W + B_W;
  localparam int NW    = P_W + FRAC_BITS;
  localparam int DW    = (TEMP_W + 1 + FRAC_BITS > B_W) ? TEMP_W + 1 + FRAC_BITS : B_W;
  localparam int CMP_W = ((TO_W > QT_W) ? TO_W : QT_W) + 1;
  localparam logic signed [NW-1:0] HOLD_VAL = NW'(64'sd1 <<< 40);
  localparam logic signed [NW-1:0] HOLD_TH  =
    NW'(((64'sd1 <<< (40 - FRAC_BITS)) + 64'sd1) <<< FRAC_BITS);

  // configuration
  logic [CNT_W-1:0] begin_count;
  logic [CNT_W-1:0] top_count;
  logic [PTS_W-1:0] points_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_count   <= RST_BEGIN;
      top_count     <= RST_TOP;
      points_in_use <= RST_POINTS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEGIN:  begin_count   <= cfg_data;
        CFG_TOP:    top_count     <= cfg_data;
        CFG_POINTS: points_in_use <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  // points in use, held to 2..TABLE_DEPTH
  logic [8:0]     pts_w;
  logic [NPW-1:0] n_pts;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  last_lo;

  always_comb begin
    pts_w = 9'(points_in_use);
    if (pts_w < 9'd2) begin
      n_pts = NPW'(2);
    end else if (pts_w > 9'(TABLE_DEPTH)) begin
      n_pts = NPW'(TABLE_DEPTH);
    end else begin
      n_pts = NPW'(pts_w);
    end
    last_idx = AW'(n_pts - NPW'(1));
    last_lo  = AW'(n_pts - NPW'(2));
  end

  state_t state, state_next;

  logic                     rd_wait;
  logic [FUNC_W-1:0]        func;
  logic [CNT_W-1:0]         ad;
  logic signed [QT_W-1:0]   tq;
  logic [AW-1:0]            k;
  logic [AW-1:0]            lo;
  logic [CNT_W-1:0]         prev;
  logic [CNT_W-1:0]         al, ah;
  logic signed [TEMP_W-1:0] tl, th;
  logic signed [CORR_W-1:0] cl, ch;
  logic signed [OUT_W-1:0]  raw;
  logic signed [P_W-1:0]    prod;
  logic signed [OUT_W-1:0]  res_temp;
  logic [CNT_W-1:0]         res_count;
  logic [STAT_W-1:0]        res_status;
  logic                     rsp_valid;

  // table
  logic          tbl_we;
  point_t        tbl_wdata;
  logic [AW-1:0] rd_addr;
  point_t        rdata;

  assign tbl_we    = req.valid && req.ready && req.func == FUNC_LOAD &&
                     9'(req.entry_index) < 9'(TABLE_DEPTH);
  assign tbl_wdata = '{count: req.entry_count, temp: req.entry_temp,
                       corr: req.entry_correction};

  iratc_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(req.entry_index)),
    .wdata (tbl_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // datapath terms
  logic signed [TEMP_W:0]   dt;
  logic signed [TO_W-1:0]   tl_one;
  logic signed [CMP_W-1:0]  tq_c;
  logic signed [CMP_W-1:0]  cur_one;
  logic signed [CMP_W-1:0]  prev_one;
  logic                     hit;
  logic                     is_temp;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic                     div_start;
  logic signed [NW-1:0]     div_num;
  logic signed [DW-1:0]     div_den;
  logic                     div_done;
  logic signed [NW-1:0]     quo;
  logic                     rem_nz;
  logic signed [NW-1:0]     held;
  logic signed [SAT_W-1:0]  fq;
  logic signed [SAT_W-1:0]  cnt;

  always_comb begin
    is_temp  = func == FUNC_TEMP;
    dt       = (TEMP_W + 1)'(th) - (TEMP_W + 1)'(tl);
    tl_one   = TO_W'(tl) <<< FRAC_BITS;
    tq_c     = CMP_W'(tq);
    cur_one  = CMP_W'(rdata.temp) <<< FRAC_BITS;
    prev_one = CMP_W'(signed'(prev)) <<< FRAC_BITS;
    if (is_temp) begin
      hit = ad >= prev && ad <= rdata.count;
    end else begin
      hit = tq_c >= prev_one && tq_c <= cur_one;
    end

    if (state == S_MUL1) begin
      if (is_temp) begin
        mul_a = A_W'(signed'({1'b0, ad})) - A_W'(signed'({1'b0, al}));
        mul_b = B_W'(dt);
      end else begin
        mul_a = A_W'(tq) - A_W'(tl_one);
        mul_b = B_W'(ch) - B_W'(cl);
      end
    end else begin
      if (is_temp) begin
        mul_a = A_W'(raw) - A_W'(cl);
        mul_b = B_W'(dt);
      end else begin
        mul_a = A_W'(raw) - A_W'(tl_one);
        mul_b = B_W'(signed'({1'b0, ah})) - B_W'(signed'({1'b0, al}));
      end
    end

    if (is_temp) begin
      div_num = NW'(prod) <<< FRAC_BITS;
      if (state == S_DIV1) begin
        div_den = DW'((TEMP_W + 1)'(signed'({1'b0, ah})) -
                      (TEMP_W + 1)'(signed'({1'b0, al})));
      end else begin
        div_den = DW'(B_W'(ch) - B_W'(cl));
      end
    end else begin
      div_num = NW'(prod);
      div_den = DW'(dt) <<< FRAC_BITS;
    end

    // quotient at 2^40 + 2^FRAC_BITS or beyond in magnitude is held to 2^40
    if (quo >= HOLD_TH) begin
      held = HOLD_VAL;
    end else if (quo <= -HOLD_TH) begin
      held = -HOLD_VAL;
    end else begin
      held = quo;
    end

    // floor from truncation: step down when inexact and the signs differ
    fq  = SAT_W'(quo) - ((rem_nz && (prod[P_W-1] ^ dt[TEMP_W])) ?
                         SAT_W'(1) : SAT_W'(0));
    cnt = SAT_W'(signed'({1'b0, al})) + fq;
  end

  iratc_div #(.NW(NW), .DW(DW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rd_addr    = k;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.func == FUNC_TEMP) begin
            if (begin_count > req.sample_count || top_count < req.sample_count) begin
              state_next = S_SEG_LO;
            end else begin
              state_next = S_SEARCH;
            end
          end else if (req.func == FUNC_COUNT) begin
            state_next = S_TOP_RD;
          end
        end
      end
      S_TOP_RD: begin
        rd_addr = last_idx;
        if (rd_wait) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        rd_addr = k;
        if (rd_wait) begin
          if (k == '0) begin
            // below the first point wins over above the last one
            if (!is_temp && (tq_c < cur_one || res_status == STAT_ABOVE)) begin
              state_next = S_OUT;
            end
          end else if (hit || k == last_idx) begin
            state_next = S_SEG_LO;
          end
        end
      end
      S_SEG_LO: begin
        rd_addr = lo;
        if (rd_wait) begin
          state_next = S_SEG_HI;
        end
      end
      S_SEG_HI: begin
        rd_addr = lo + AW'(1);
        if (rd_wait) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (is_temp ? (ah == al || ch == cl) : (th == tl)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: state_next = S_DIV1;
      S_DIV1: begin
        div_start = !rd_wait;
        if (rd_wait && div_done) begin
          state_next = S_FIX1;
        end
      end
      S_FIX1: state_next = S_MUL2;
      S_MUL2: state_next = S_DIV2;
      S_DIV2: begin
        div_start = !rd_wait;
        if (rd_wait && div_done) begin
          state_next = S_FIX2;
        end
      end
      S_FIX2: state_next = S_OUT;
      S_OUT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // phase bit: memory data or divider result pending
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_wait <= 1'b0;
    end else if (state_next != state) begin
      rd_wait <= 1'b0;
    end else if (state == S_DIV1 || state == S_DIV2) begin
      rd_wait <= 1'b1;
    end else begin
      rd_wait <= !rd_wait;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        func       <= req.func;
        ad         <= req.sample_count;
        tq         <= req.query_temp;
        k          <= '0;
        res_status <= STAT_OK;
        lo         <= (begin_count > req.sample_count) ? '0 : last_lo;
        if (req.func == FUNC_TEMP) begin
          res_count <= req.sample_count;
          res_temp  <= '0;
        end else begin
          res_count <= '0;
          res_temp  <= OUT_W'(req.query_temp);
        end
      end
      S_TOP_RD: begin
        if (rd_wait && tq_c > cur_one) begin
          res_status <= STAT_ABOVE;
        end
      end
      S_SEARCH: begin
        if (rd_wait) begin
          prev <= is_temp ? rdata.count : CNT_W'(rdata.temp);
          k    <= k + AW'(1);
          if (k == '0) begin
            if (!is_temp && tq_c < cur_one) begin
              res_status <= STAT_BELOW;
            end
          end else if (hit) begin
            lo <= k - AW'(1);
          end else if (k == last_idx) begin
            lo <= last_lo;
          end
        end
      end
      S_SEG_LO: begin
        al <= rdata.count;
        tl <= rdata.temp;
        cl <= rdata.corr;
      end
      S_SEG_HI: begin
        ah <= rdata.count;
        th <= rdata.temp;
        ch <= rdata.corr;
      end
      S_CHECK: begin
        if (is_temp ? (ah == al || ch == cl) : (th == tl)) begin
          res_status <= STAT_ZERO;
        end
      end
      S_MUL1, S_MUL2: prod <= P_W'(mul_a) * P_W'(mul_b);
      S_FIX1: begin
        if (is_temp) begin
          raw <= sat32(SAT_W'(tl_one) + SAT_W'(held));
        end else begin
          raw <= sat32(SAT_W'(cl) + SAT_W'(quo));
        end
      end
      S_FIX2: begin
        if (is_temp) begin
          res_temp <= sat32(SAT_W'(tl_one) + SAT_W'(held));
        end else if (cnt < 0) begin
          res_count <= '0;
        end else if (cnt > SAT_W'(65535)) begin
          res_count <= '1;
        end else begin
          res_count <= cnt[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp_valid || rsp.ready)) begin
      rsp.temperature <= res_temp;
      rsp.count_value <= res_count;
      rsp.status      <= res_status;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule
`default_nettype wire

[hdl/iratc_table.sv]
// iratc_table: calibration point memory, one write and one registered read port
// depends on iratc_pkg
`default_nettype none
module iratc_table #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  wire iratc_pkg::point_t wdata,
  input  wire [AW-1:0]         raddr,
  output iratc_pkg::point_t    rdata
);
  import iratc_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/iratc_div.sv]
// iratc_div: signed restoring divider, one quotient bit per cycle, truncating
// depends on iratc_pkg
`default_nettype none
module iratc_div #(
  parameter int NW = 66,
  parameter int DW = 25,
  parameter int CW = $clog2(NW + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire signed [NW-1:0]  num,
  input  wire signed [DW-1:0]  den,
  output logic                 done,
  output logic signed [NW-1:0] quo,
  output logic                 rem_nz
);
  import iratc_pkg::*;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] dmag;
  logic          neg;
  logic [DW:0]   sh;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    sh       = {rem, q[NW-1]};
    ge       = sh >= {1'b0, dmag};
    rem_next = ge ? DW'(sh - {1'b0, dmag}) : DW'(sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num[NW-1] ? NW'(-num) : NW'(num);
      dmag <= den[DW-1] ? DW'(-den) : DW'(den);
      neg  <= num[NW-1] ^ den[DW-1];
      rem  <= '0;
    end else if (busy) begin
      q   <= {q[NW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quo    = neg ? -signed'(q) : signed'(q);
  assign rem_nz = |rem;

endmodule
`default_nettype wire

[hdl/iratc_check.sv]
// iratc_check: port-level checks of the converter, bound to the top level
// depends on iratc_pkg and ir_ad_temperature_table_convert
`default_nettype none
module iratc_check (
  input wire                         clk,
  input wire                         rst,
  input wire                         req_valid,
  input wire                         req_ready,
  input wire [iratc_pkg::FUNC_W-1:0] req_func,
  input wire                         rsp_valid,
  input wire                         rsp_ready
);
  import iratc_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // nothing is offered right after reset
  a_rst_clear: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

  // a conversion transfer occupies the sequencer
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func == FUNC_TEMP || req_func == FUNC_COUNT)
    |=> !req_ready)
    else $error("ready high right after a conversion transfer");

  // a load finishes in its transfer cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_LOAD |=> req_ready)
    else $error("load did not return to idle");

endmodule

bind ir_ad_temperature_table_convert iratc_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.func),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);
`default_nettype wire

[dv/ir_ad_temperature_table_convert_test.sv]
// ir_ad_temperature_table_convert_test: self-checking bench for the calibration table converter
// depends on iratc_pkg, iratc_req_if, iratc_rsp_if and the converter rtl
`timescale 1ns / 100ps
`default_nettype none
module ir_ad_temperature_table_convert_test;
  import iratc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int DEPTH = 64;
  localparam longint ONE_Q = 256;
  localparam longint HOLD_Q = longint'(1) << 40;
  localparam int SETTLE = 400;

  typedef struct {
    logic        [FUNC_W-1:0] func;
    logic        [IDX_W-1:0]  idx;
    logic        [CNT_W-1:0]  cnt;
    logic signed [TEMP_W-1:0] temp;
    logic signed [CORR_W-1:0] corr;
    logic        [CNT_W-1:0]  sample;
    logic signed [QT_W-1:0]   qtemp;
  } conv_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] temperature;
    logic        [CNT_W-1:0] count_value;
    logic       [STAT_W-1:0] status;
  } conv_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  iratc_req_if req ();
  iratc_rsp_if rsp ();

  ir_ad_temperature_table_convert u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint pt_count [DEPTH];
  longint pt_temp [DEPTH];
  longint pt_corr [DEPTH];
  longint begin_cnt, top_cnt, pts_used;

  conv_item_t pending_items[$];
  conv_result_t expected_results[$];
  int mismatches = 0;
  bit req_taken = 0;
  int req_gap = 0;
  int rsp_gap = 0;
  bit calm = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scaled_quot(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (q > HOLD_Q / ONE_Q) return HOLD_Q;
    if (q < -(HOLD_Q / ONE_Q)) return -HOLD_Q;
    return q * ONE_Q + (r * ONE_Q) / d;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if (n % d < 0) q = q - 1;
    return q;
  endfunction

  function automatic int points_active();
    if (pts_used < 2) return 2;
    if (pts_used > DEPTH) return DEPTH;
    return int'(pts_used);
  endfunction

  // returns 1 when the item produces a result
  function automatic bit convert(input conv_item_t it, output conv_result_t res);
    int n, lo;
    longint ad, tq, tl, th, al, ah, cl, ch, dt, raw, den, corr, cnt, tout;
    n = points_active();
    res.status = STAT_OK;
    res.count_value = '0;
    tout = 0;
    if (it.func == FUNC_LOAD) begin
      pt_count[it.idx] = it.cnt;
      pt_temp[it.idx] = it.temp;
      pt_corr[it.idx] = it.corr;
      return 0;
    end
    if (it.func == FUNC_NONE) return 0;
    if (it.func == FUNC_TEMP) begin
      ad = it.sample;
      res.count_value = it.sample;
      lo = n - 2;
      if (begin_cnt > ad) begin
        lo = 0;
      end else if (top_cnt >= ad) begin
        for (int i = 0; i + 1 < n; i++) begin
          if (ad >= pt_count[i] && ad <= pt_count[i+1]) begin
            lo = i;
            break;
          end
        end
      end
      tl = pt_temp[lo]; th = pt_temp[lo+1];
      al = pt_count[lo]; ah = pt_count[lo+1];
      cl = pt_corr[lo]; ch = pt_corr[lo+1];
      dt = th - tl;
      if (ah == al || ch == cl) begin
        res.status = STAT_ZERO;
      end else begin
        raw = sat_word(tl * ONE_Q + scaled_quot(dt * (ad - al), ah - al));
        tout = sat_word(tl * ONE_Q + scaled_quot((raw - cl) * dt, ch - cl));
      end
    end else begin
      tq = it.qtemp;
      tout = tq;
      if (tq < pt_temp[0] * ONE_Q) begin
        res.status = STAT_BELOW;
      end else if (tq > pt_temp[n-1] * ONE_Q) begin
        res.status = STAT_ABOVE;
      end else begin
        lo = n - 2;
        for (int i = 0; i + 1 < n; i++) begin
          if (tq >= pt_temp[i] * ONE_Q && tq <= pt_temp[i+1] * ONE_Q) begin
            lo = i;
            break;
          end
        end
        tl = pt_temp[lo]; th = pt_temp[lo+1];
        al = pt_count[lo]; ah = pt_count[lo+1];
        cl = pt_corr[lo]; ch = pt_corr[lo+1];
        dt = th - tl;
        if (dt == 0) begin
          res.status = STAT_ZERO;
        end else begin
          den = dt * ONE_Q;
          corr = sat_word(cl + ((tq - tl * ONE_Q) * (ch - cl)) / den);
          cnt = al + floor_quot((ah - al) * (corr - tl * ONE_Q), den);
          if (cnt < 0) cnt = 0;
          if (cnt > 65535) cnt = 65535;
          res.count_value = cnt[CNT_W-1:0];
        end
      end
    end
    res.temperature = tout[OUT_W-1:0];
    return 1;
  endfunction

  function automatic conv_item_t noise_item(logic [FUNC_W-1:0] f);
    conv_item_t it;
    it.func = f;
    it.idx = IDX_W'($urandom);
    it.cnt = CNT_W'($urandom);
    it.temp = TEMP_W'($urandom);
    it.corr = CORR_W'($urandom);
    it.sample = CNT_W'($urandom);
    it.qtemp = QT_W'($urandom);
    return it;
  endfunction

  function automatic void push_load(int i, longint c, longint t, longint k);
    conv_item_t it;
    it = noise_item(FUNC_LOAD);
    it.idx = IDX_W'(i);
    it.cnt = CNT_W'(c);
    it.temp = TEMP_W'(t);
    it.corr = CORR_W'(k);
    pending_items.push_back(it);
  endfunction

  // increasing table, with the odd flat step for zero-width segments when flats is set
  function automatic void load_ordered_table(bit flats, int n_load);
    longint c, t;
    c = $urandom_range(0, 3000);
    t = -longint'($urandom_range(0, 60));
    for (int i = 0; i < n_load; i++) begin
      push_load(i, c, t, t * ONE_Q + $urandom_range(0, 400) - 200);
      c = c + ((flats && $urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 900));
      if (c > 65535) c = 65535;
      t = t + ((flats && $urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6));
    end
  endfunction

  function automatic void load_noise_table(int n_load);
    for (int i = 0; i < n_load; i++) begin
      conv_item_t it;
      it = noise_item(FUNC_LOAD);
      it.idx = IDX_W'(i);
      pending_items.push_back(it);
    end
  endfunction

  function automatic conv_item_t sample_item();
    conv_item_t it;
    int j;
    longint a, b;
    it = noise_item(FUNC_TEMP);
    j = $urandom_range(0, points_active() - 2);
    a = pt_count[j];
    b = pt_count[j+1];
    case ($urandom_range(0, 9))
      0: it.sample = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      1, 2: ;
      default: begin
        if (b > a) it.sample = CNT_W'(a + $urandom_range(0, int'(b - a)));
        else it.sample = CNT_W'(a);
      end
    endcase
    return it;
  endfunction

  function automatic conv_item_t query_item();
    conv_item_t it;
    int j;
    longint a, b;
    it = noise_item(FUNC_COUNT);
    j = $urandom_range(0, points_active() - 2);
    a = pt_temp[j] * ONE_Q;
    b = pt_temp[j+1] * ONE_Q;
    case ($urandom_range(0, 9))
      0: it.qtemp = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1: ;
      default: begin
        if (b > a) it.qtemp = QT_W'(a + $urandom_range(0, int'(b - a)));
        else it.qtemp = QT_W'(a);
      end
    endcase
    return it;
  endfunction

  function automatic void random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 19);
      if (r < 2) pending_items.push_back(noise_item(FUNC_LOAD));
      else if (r == 2) pending_items.push_back(noise_item(FUNC_NONE));
      else if (r < 11) pending_items.push_back(sample_item());
      else pending_items.push_back(query_item());
    end
  endfunction

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !req.valid);
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_BEGIN: begin_cnt = value;
      CFG_TOP: top_cnt = value;
      default: pts_used = value[PTS_W-1:0];
    endcase
  endtask

  // only the points in use are loaded
  task automatic run_phase(longint b, longint t, longint p, int table_kind, int count);
    int np;
    write_reg(CFG_BEGIN, CFG_W'(b));
    write_reg(CFG_TOP, CFG_W'(t));
    write_reg(CFG_POINTS, CFG_W'(p));
    np = points_active();
    calm = $urandom_range(0, 2) == 0;
    if (table_kind == 0) load_ordered_table(0, np);
    else if (table_kind == 1) load_ordered_table(1, np);
    else load_noise_table(np);
    wait (pending_items.size() == 0);
    random_items(count);
    wait_idle();
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        conv_item_t it;
        it = pending_items.pop_front();
        req.func <= it.func;
        req.entry_index <= it.idx;
        req.entry_count <= it.cnt;
        req.entry_temp <= it.temp;
        req.entry_correction <= it.corr;
        req.sample_count <= it.sample;
        req.query_temp <= it.qtemp;
        req.valid <= 1'b1;
        if (calm) req_gap <= 0;
        else if ($urandom_range(0, 9) < 8) req_gap <= $urandom_range(0, 2);
        else req_gap <= $urandom_range(10, 60);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rsp_gap > 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) < 8) rsp_gap <= $urandom_range(1, 3);
        else rsp_gap <= $urandom_range(20, 300);
      end
    end
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    req_taken = !rst && req.valid && req.ready;
    if (req_taken) begin
      conv_item_t it;
      conv_result_t res;
      it.func = req.func;
      it.idx = req.entry_index;
      it.cnt = req.entry_count;
      it.temp = req.entry_temp;
      it.corr = req.entry_correction;
      it.sample = req.sample_count;
      it.qtemp = req.query_temp;
      if (convert(it, res)) expected_results.push_back(res);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      conv_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer temp=%0d count=%0d status=%0d",
                                       rsp.temperature, rsp.count_value, rsp.status);
      end else begin
        want = expected_results.pop_front();
        if (rsp.temperature !== want.temperature || rsp.count_value !== want.count_value ||
            rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp %0d/%0d count %0d/%0d status %0d/%0d (exp/act)",
                     want.temperature, rsp.temperature, want.count_value,
                     rsp.count_value, want.status, rsp.status);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    conv_item_t it;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.func = '0;
    req.entry_index = '0;
    req.entry_count = '0;
    req.entry_temp = '0;
    req.entry_correction = '0;
    req.sample_count = '0;
    req.query_temp = '0;
    rsp.ready = 1'b0;
    begin_cnt = RST_BEGIN;
    top_cnt = RST_TOP;
    pts_used = RST_POINTS;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset config, two points in use, extremes loaded past them
    load_ordered_table(0, DEPTH);
    push_load(62, 16'h0000, -32768, -8388608);
    push_load(63, 16'hffff, 32767, 8388607);
    wait (pending_items.size() == 0);
    it = noise_item(FUNC_TEMP); it.sample = 16'h0000; pending_items.push_back(it);
    it = noise_item(FUNC_TEMP); it.sample = 16'hffff; pending_items.push_back(it);
    it = noise_item(FUNC_TEMP); it.sample = RST_BEGIN - 16'd1; pending_items.push_back(it);
    it = noise_item(FUNC_TEMP); it.sample = RST_BEGIN; pending_items.push_back(it);
    it = noise_item(FUNC_COUNT); it.qtemp = 24'sh800000; pending_items.push_back(it);
    it = noise_item(FUNC_COUNT); it.qtemp = 24'sh7fffff; pending_items.push_back(it);
    it = noise_item(FUNC_NONE); pending_items.push_back(it);
    // flat segment on points 0 and 1: both zero-width paths
    push_load(1, 2000, 5, 1280);
    push_load(0, 2000, 5, 1280);
    it = noise_item(FUNC_TEMP); it.sample = 16'd2000; pending_items.push_back(it);
    it = noise_item(FUNC_COUNT); it.qtemp = 24'sd1280; pending_items.push_back(it);
    push_load(0, 1000, -10, -2560);
    push_load(1, 9000, 40, 10240 + 77);
    random_items(8);
    wait_idle();

    run_phase(0, 65535, 64, 0, 40);
    run_phase(65535, 0, 0, 2, 30);
    run_phase(1500, 40000, 127, 1, 40);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), 1, 2, 30);
    run_phase($urandom_range(0, 5000), $urandom_range(30000, 65535),
              $urandom_range(2, 64), 0, 40);
    run_phase($urandom_range(0, 65535), 65535, $urandom_range(2, 127), 1, 40);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
hdl/iratc_pkg.sv
hdl/iratc_req_if.sv
hdl/iratc_rsp_if.sv
hdl/iratc_table.sv
hdl/iratc_div.sv
hdl/ir_ad_temperature_table_convert.sv
hdl/iratc_check.sv
dv/ir_ad_temperature_table_convert_test.sv
